@@ src/gsd_pkg.sv @@
package gsd_pkg;

    localparam int CAP_W = 20;
    localparam int BTN_W = 16;
    localparam int AXIS_W = 8;
    localparam int THR_W = 7;
    localparam int TIME_W = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CAP_W-1:0] CAP_MASK = 20'hf06fe;
    localparam logic [CAP_W-1:0] CAP_FULL = 20'hf06fe;
    localparam logic [CAP_W-1:0] CAP_DIGITAL = 20'h700fe;

    localparam int BTN_B = 1;
    localparam int BTN_A = 2;
    localparam int BTN_START = 3;
    localparam int BTN_UP = 4;
    localparam int BTN_DOWN = 5;
    localparam int BTN_LEFT = 6;
    localparam int BTN_RIGHT = 7;
    localparam int BTN_Y = 9;
    localparam int BTN_X = 10;

    localparam logic [BTN_W-1:0] MASK_ABXY = 16'h0606;
    localparam logic [BTN_W-1:0] MASK_DIRS = 16'h00f0;

    localparam logic [1:0] MODE_FULL = 2'd0;
    localparam logic [1:0] MODE_DIGITAL = 2'd1;
    localparam logic [1:0] MODE_NONE = 2'd2;

    localparam logic [1:0] DIR_NEUTRAL = 2'd0;
    localparam logic [1:0] DIR_NEG = 2'd1;
    localparam logic [1:0] DIR_POS = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_STICK_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_DELAY = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_PERIOD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_AFTER = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_PERIOD = 3'd4;

    localparam logic [THR_W-1:0] RST_STICK_THRESHOLD = 7'd64;
    localparam logic [TIME_W-1:0] RST_INITIAL_DELAY = 8'd15;
    localparam logic [TIME_W-1:0] RST_REPEAT_PERIOD = 8'd6;
    localparam logic [TIME_W-1:0] RST_ACCEL_AFTER = 8'd30;
    localparam logic [TIME_W-1:0] RST_FAST_PERIOD = 8'd1;

    typedef struct packed {
        logic [THR_W-1:0]  stick_threshold;
        logic [TIME_W-1:0] initial_delay;
        logic [TIME_W-1:0] repeat_period;
        logic [TIME_W-1:0] accel_after;
        logic [TIME_W-1:0] fast_period;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        x_latch;
        logic [1:0]        y_latch;
        logic              repeat_active;
        logic [TIME_W-1:0] repeat_counter;
        logic [TIME_W-1:0] current_period;
        logic [TIME_W-1:0] hold_frames;
    } t_state;

    typedef struct packed {
        logic [BTN_W-1:0] held_out;
        logic [BTN_W-1:0] pressed_out;
        logic             reset_request;
        logic [1:0]       controller_mode;
    } t_result;

endpackage

@@ src/gamepad_stick_to_dpad_autorepeat.sv @@
// gamepad stick to d-pad merge with direction auto-repeat
//
// input channel: i_in_valid / o_in_ready carry one controller poll per
// transfer (controller flag, capability mask, stick axes, held and new
// buttons). output channel: o_out_valid / i_out_ready carry one result per
// poll (merged held buttons, press edges, reset request, controller mode).
// configuration: i_cfg_wr_en with i_cfg_index and i_cfg_data writes one
// register; indexes past the last register are dropped.
// path: a poll is held in the input register, passes the combinational
// state update, and its result is held in the result register until taken.
// throughput: one poll per cycle while the receiver takes results, through
// the combinational state update between the two registers.
// when the receiver stalls the result register holds its item, the input
// register still takes one more poll, and o_in_ready then drops until the
// result is taken.
// reset: both registers empty, direction latches and repeat state cleared,
// configuration back to its defaults.
module gamepad_stick_to_dpad_autorepeat (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [gsd_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [gsd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_is_controller,
    input  logic [gsd_pkg::CAP_W-1:0]            i_capabilities,
    input  logic signed [gsd_pkg::AXIS_W-1:0]    i_stick_x,
    input  logic signed [gsd_pkg::AXIS_W-1:0]    i_stick_y,
    input  logic [gsd_pkg::BTN_W-1:0]            i_held_buttons,
    input  logic [gsd_pkg::BTN_W-1:0]            i_new_buttons,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [gsd_pkg::BTN_W-1:0]            o_held_out,
    output logic [gsd_pkg::BTN_W-1:0]            o_pressed_out,
    output logic                                 o_reset_request,
    output logic [1:0]                           o_controller_mode
);
    import gsd_pkg::*;

    t_cfg                    r_cfg;
    t_state                  r_state;
    t_state                  n_state;
    t_result                 r_out;
    t_result                 n_out;
    logic                    r_in_valid;
    logic                    r_out_valid;
    logic                    r_is_controller;
    logic [CAP_W-1:0]        r_capabilities;
    logic signed [AXIS_W-1:0] r_stick_x;
    logic signed [AXIS_W-1:0] r_stick_y;
    logic [BTN_W-1:0]        r_held_buttons;
    logic [BTN_W-1:0]        r_new_buttons;
    logic                    advance;
    logic                    in_xfer;

    assign advance = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer = i_in_valid && o_in_ready;

    gsd_step u_step (
        .i_cfg           (r_cfg),
        .i_state         (r_state),
        .i_is_controller (r_is_controller),
        .i_capabilities  (r_capabilities),
        .i_stick_x       (r_stick_x),
        .i_stick_y       (r_stick_y),
        .i_held_buttons  (r_held_buttons),
        .i_new_buttons   (r_new_buttons),
        .o_state         (n_state),
        .o_result        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stick_threshold <= RST_STICK_THRESHOLD;
            r_cfg.initial_delay <= RST_INITIAL_DELAY;
            r_cfg.repeat_period <= RST_REPEAT_PERIOD;
            r_cfg.accel_after <= RST_ACCEL_AFTER;
            r_cfg.fast_period <= RST_FAST_PERIOD;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STICK_THRESHOLD: r_cfg.stick_threshold <= i_cfg_data[THR_W-1:0];
                CFG_INITIAL_DELAY:   r_cfg.initial_delay <= i_cfg_data[TIME_W-1:0];
                CFG_REPEAT_PERIOD:   r_cfg.repeat_period <= i_cfg_data[TIME_W-1:0];
                CFG_ACCEL_AFTER:     r_cfg.accel_after <= i_cfg_data[TIME_W-1:0];
                CFG_FAST_PERIOD:     r_cfg.fast_period <= i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_state <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_is_controller <= i_is_controller;
            r_capabilities <= i_capabilities;
            r_stick_x <= i_stick_x;
            r_stick_y <= i_stick_y;
            r_held_buttons <= i_held_buttons;
            r_new_buttons <= i_new_buttons;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_held_out = r_out.held_out;
    assign o_pressed_out = r_out.pressed_out;
    assign o_reset_request = r_out.reset_request;
    assign o_controller_mode = r_out.controller_mode;

endmodule

@@ src/gsd_step.sv @@
module gsd_step (
    input  gsd_pkg::t_cfg                        i_cfg,
    input  gsd_pkg::t_state                      i_state,
    input  logic                                 i_is_controller,
    input  logic [gsd_pkg::CAP_W-1:0]            i_capabilities,
    input  logic signed [gsd_pkg::AXIS_W-1:0]    i_stick_x,
    input  logic signed [gsd_pkg::AXIS_W-1:0]    i_stick_y,
    input  logic [gsd_pkg::BTN_W-1:0]            i_held_buttons,
    input  logic [gsd_pkg::BTN_W-1:0]            i_new_buttons,
    output gsd_pkg::t_state                      o_state,
    output gsd_pkg::t_result                     o_result
);
    import gsd_pkg::*;

    logic [CAP_W-1:0]        caps;
    logic signed [AXIS_W:0]  thr_pos;
    logic signed [AXIS_W:0]  thr_neg;
    logic signed [AXIS_W:0]  sx;
    logic signed [AXIS_W:0]  sy;
    logic [BTN_W-1:0]        held;
    logic [BTN_W-1:0]        pressed;
    logic [BTN_W-1:0]        dirs;
    logic [TIME_W-1:0]       cnt_inc;
    logic [TIME_W-1:0]       hold_inc;
    t_state                  nxt;
    logic                    req;
    logic [1:0]              mode;

    assign caps = i_capabilities & CAP_MASK;
    assign thr_pos = $signed({2'b00, i_cfg.stick_threshold});
    assign thr_neg = -thr_pos;
    assign sx = {i_stick_x[AXIS_W-1], i_stick_x};
    assign sy = {i_stick_y[AXIS_W-1], i_stick_y};
    assign cnt_inc = i_state.repeat_counter + TIME_W'(1);
    assign hold_inc = (i_state.hold_frames != {TIME_W{1'b1}}) ?
                      i_state.hold_frames + TIME_W'(1) : i_state.hold_frames;

    always_comb begin
        nxt = i_state;
        held = '0;
        pressed = '0;
        req = 1'b0;
        mode = MODE_NONE;

        if (i_is_controller && (caps == CAP_FULL || caps == CAP_DIGITAL)) begin
            held = i_held_buttons;
            pressed = i_new_buttons;
            if (caps == CAP_FULL) begin
                mode = MODE_FULL;
                if (sx < thr_neg) begin
                    held[BTN_LEFT] = 1'b1;
                    if (i_state.x_latch != DIR_NEG) pressed[BTN_LEFT] = 1'b1;
                    nxt.x_latch = DIR_NEG;
                end else if (sx > thr_pos) begin
                    held[BTN_RIGHT] = 1'b1;
                    if (i_state.x_latch != DIR_POS) pressed[BTN_RIGHT] = 1'b1;
                    nxt.x_latch = DIR_POS;
                end else begin
                    nxt.x_latch = DIR_NEUTRAL;
                end
                if (sy < thr_neg) begin
                    held[BTN_UP] = 1'b1;
                    if (i_state.y_latch != DIR_NEG) pressed[BTN_UP] = 1'b1;
                    nxt.y_latch = DIR_NEG;
                end else if (sy > thr_pos) begin
                    held[BTN_DOWN] = 1'b1;
                    if (i_state.y_latch != DIR_POS) pressed[BTN_DOWN] = 1'b1;
                    nxt.y_latch = DIR_POS;
                end else begin
                    nxt.y_latch = DIR_NEUTRAL;
                end
            end else begin
                mode = MODE_DIGITAL;
            end
            if (i_new_buttons[BTN_START] && ((i_held_buttons & MASK_ABXY) == MASK_ABXY)) begin
                req = 1'b1;
            end
        end

        dirs = held & MASK_DIRS;

        if (!i_state.repeat_active) begin
            if (dirs != '0) begin
                nxt.repeat_active = 1'b1;
                nxt.repeat_counter = '0;
                nxt.current_period = i_cfg.initial_delay;
                nxt.hold_frames = '0;
            end
        end else if (dirs == '0) begin
            nxt.repeat_active = 1'b0;
        end else begin
            nxt.repeat_counter = cnt_inc;
            if (i_state.current_period <= cnt_inc) begin
                nxt.repeat_counter = '0;
                nxt.current_period = i_cfg.repeat_period;
                pressed = pressed | dirs;
            end
            nxt.hold_frames = hold_inc;
            if (hold_inc > i_cfg.accel_after) nxt.current_period = i_cfg.fast_period;
        end

        o_state = nxt;
        o_result.held_out = held;
        o_result.pressed_out = pressed;
        o_result.reset_request = req;
        o_result.controller_mode = mode;
    end

endmodule

@@ src/gsd_checker.sv @@
module gsd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [gsd_pkg::BTN_W-1:0]     o_held_out,
    input logic [gsd_pkg::BTN_W-1:0]     o_pressed_out,
    input logic                          o_reset_request,
    input logic [1:0]                    o_controller_mode
);
    import gsd_pkg::*;

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_held_out) &&
        $stable(o_pressed_out) && $stable(o_reset_request) &&
        $stable(o_controller_mode))
        else $error("stalled result changed");

    // result register empties on reset
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // unsupported device gives no buttons and no reset request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_controller_mode == MODE_NONE |->
        o_held_out == '0 && o_pressed_out == '0 && !o_reset_request)
        else $error("unsupported device passed buttons");

    // reset request only with abxy held and start pressed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reset_request |->
        (o_held_out & MASK_ABXY) == MASK_ABXY && o_pressed_out[BTN_START])
        else $error("reset request without button combination");

    // mode is never the unused code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_controller_mode == MODE_FULL ||
        o_controller_mode == MODE_DIGITAL || o_controller_mode == MODE_NONE)
        else $error("bad controller mode");

endmodule

bind gamepad_stick_to_dpad_autorepeat gsd_checker u_gsd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_held_out        (o_held_out),
    .o_pressed_out     (o_pressed_out),
    .o_reset_request   (o_reset_request),
    .o_controller_mode (o_controller_mode)
);
